[rtl/rts_pkg.sv]
package rts_pkg;

  // Fixed field widths of the command and result ports
  localparam int unsigned OP_W     = 2;
  localparam int unsigned ITEM_W   = 32;
  localparam int unsigned TICKET_W = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  // Widest value a cell may keep; values are staged at this width
  localparam int unsigned VALUE_MAX_W = 64;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_POP    = 2'd1,
    OP_COUNT  = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EXHAUSTED = 2'd3
  } status_e;

  // Control half of the wave that walks the cell row
  typedef struct packed {
    logic vld;    // a command occupies this hop
    op_e  op;
    logic done;   // a cell upstream already claimed or hit
    logic allow;  // insert may take a receipt (counter not at max)
  } wave_ctl_t;

endpackage

[rtl/receipt_tagged_store_top.sv]
// Channel  | Handshake            | Fields
// ---------+----------------------+--------------------------------------------------
// command  | start_i / busy_o     | op_i, item_value_i, ticket_i
// result   | done_o (strobe)      | status_o, issued_ticket_o, popped_value_o,
//          |                      | match_count_o, occupancy_o
//
// A command is taken when start_i is high and busy_o low. It travels the row
// of CAPACITY slot cells one cell per cycle; done_o is registered from the
// wave leaving the last cell, and the beat is taken at the edge that ends the
// done_o cycle. busy_o drops in that same done_o cycle, so no new command is
// taken until the last one has walked the cell row. Reset clears all slot
// valid bits, the receipt counter and the occupancy at once. The receiver
// cannot stall: a result beat is valid for its single done_o cycle only.
module receipt_tagged_store_top #(
  parameter int unsigned CAPACITY    = 16,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [rts_pkg::OP_W-1:0]            op_i,
  input  logic signed [rts_pkg::ITEM_W-1:0]   item_value_i,
  input  logic [rts_pkg::TICKET_W-1:0]        ticket_i,
  output logic                                done_o,
  output logic [rts_pkg::STATUS_W-1:0]        status_o,
  output logic [rts_pkg::TICKET_W-1:0]        issued_ticket_o,
  output logic signed [rts_pkg::ITEM_W-1:0]   popped_value_o,
  output logic [rts_pkg::COUNT_W-1:0]         match_count_o,
  output logic [rts_pkg::COUNT_W-1:0]         occupancy_o
);
  import rts_pkg::*;

  localparam int unsigned VW = VALUE_WIDTH;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  // Wave links between cells; index 0 is the launch point
  wave_ctl_t           ctl_w [CAPACITY+1];
  logic [VW-1:0]       val_w [CAPACITY+1];
  logic [TICKET_W-1:0] tkt_w [CAPACITY+1];
  logic [CW-1:0]       cnt_w [CAPACITY+1];
  logic [VW-1:0]       pop_w [CAPACITY+1];

  logic                busy_q, busy_d;
  logic [TICKET_W-1:0] counter_q, counter_d;
  logic [CW-1:0]       stored_q, stored_d;
  logic                accept;
  logic                fin;
  op_e                 op_in;
  logic [VALUE_MAX_W-1:0]        val_ext;
  logic signed [VALUE_MAX_W-1:0] pop_ext;

  // Result registers
  logic                done_q;
  status_e             status_q, status_d;
  logic [TICKET_W-1:0] issued_q, issued_d;
  logic [ITEM_W-1:0]   popped_q, popped_d;
  logic [CW-1:0]       match_q;

  assign accept  = start_i && !busy_q;
  assign op_in   = op_e'(op_i);
  assign val_ext = VALUE_MAX_W'($unsigned(item_value_i));

  // Launch: the receipt to be issued rides with an insert
  always_comb begin
    ctl_w[0].vld   = accept;
    ctl_w[0].op    = op_in;
    ctl_w[0].done  = 1'b0;
    ctl_w[0].allow = (counter_q != '1);
    val_w[0]       = val_ext[VW-1:0];
    tkt_w[0]       = (op_in == OP_INSERT) ? (counter_q + TICKET_W'(1)) : ticket_i;
    cnt_w[0]       = '0;
    pop_w[0]       = '0;
  end

  // Row of slot cells
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    rts_cell #(
      .VW (VW),
      .CW (CW)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl_w[g]),
      .val_i  (val_w[g]),
      .tkt_i  (tkt_w[g]),
      .cnt_i  (cnt_w[g]),
      .pop_i  (pop_w[g]),
      .ctl_o  (ctl_w[g+1]),
      .val_o  (val_w[g+1]),
      .tkt_o  (tkt_w[g+1]),
      .cnt_o  (cnt_w[g+1]),
      .pop_o  (pop_w[g+1])
    );
  end

  assign fin     = ctl_w[CAPACITY].vld;
  assign pop_ext = VALUE_MAX_W'(signed'(pop_w[CAPACITY]));

  // Wave leaves the row: settle status, counter and occupancy
  always_comb begin
    busy_d    = busy_q;
    counter_d = counter_q;
    stored_d  = stored_q;
    status_d  = ST_OK;
    issued_d  = '0;
    popped_d  = '0;
    if (accept) begin
      busy_d = 1'b1;
    end
    if (fin) begin
      busy_d = 1'b0;
      case (ctl_w[CAPACITY].op)
        OP_INSERT: begin
          if (!ctl_w[CAPACITY].done) begin
            status_d = ST_FULL;
          end else if (!ctl_w[CAPACITY].allow) begin
            status_d = ST_EXHAUSTED;
          end else begin
            counter_d = tkt_w[CAPACITY];
            issued_d  = tkt_w[CAPACITY];
            stored_d  = stored_q + CW'(1);
          end
        end
        OP_POP: begin
          if (!ctl_w[CAPACITY].done) begin
            status_d = ST_NOT_FOUND;
          end else begin
            popped_d = pop_ext[ITEM_W-1:0];
            stored_d = stored_q - CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      counter_q <= '0;
      stored_q  <= '0;
      done_q    <= 1'b0;
    end else begin
      busy_q    <= busy_d;
      counter_q <= counter_d;
      stored_q  <= stored_d;
      done_q    <= fin;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (fin) begin
      status_q <= status_d;
      issued_q <= issued_d;
      popped_q <= popped_d;
      match_q  <= cnt_w[CAPACITY];
    end
  end

  assign busy_o          = busy_q;
  assign done_o          = done_q;
  assign status_o        = status_q;
  assign issued_ticket_o = issued_q;
  assign popped_value_o  = signed'(popped_q);
  assign match_count_o   = COUNT_W'(match_q);
  assign occupancy_o     = COUNT_W'(stored_q);

endmodule

[rtl/rts_cell.sv]
module rts_cell #(
  parameter int unsigned VW = 32,
  parameter int unsigned CW = 5
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  rts_pkg::wave_ctl_t             ctl_i,
  input  logic [VW-1:0]                  val_i,
  input  logic [rts_pkg::TICKET_W-1:0]   tkt_i,
  input  logic [CW-1:0]                  cnt_i,
  input  logic [VW-1:0]                  pop_i,
  output rts_pkg::wave_ctl_t             ctl_o,
  output logic [VW-1:0]                  val_o,
  output logic [rts_pkg::TICKET_W-1:0]   tkt_o,
  output logic [CW-1:0]                  cnt_o,
  output logic [VW-1:0]                  pop_o
);
  import rts_pkg::*;

  // Slot state
  logic                valid_q, valid_d;
  logic [VW-1:0]       value_q;
  logic [TICKET_W-1:0] ticket_q;
  logic                wr;

  // Wave stage toward the next cell
  wave_ctl_t           ctl_q, ctl_d;
  logic [VW-1:0]       val_q;
  logic [TICKET_W-1:0] tkt_q;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [VW-1:0]       pop_q, pop_d;

  // Act on the beat passing through this cell
  always_comb begin
    valid_d = valid_q;
    ctl_d   = ctl_i;
    cnt_d   = cnt_i;
    pop_d   = pop_i;
    wr      = 1'b0;
    if (ctl_i.vld) begin
      case (ctl_i.op)
        OP_INSERT: begin
          // first free slot claims the insert; it fills only if a receipt exists
          if (!ctl_i.done && !valid_q) begin
            ctl_d.done = 1'b1;
            if (ctl_i.allow) begin
              valid_d = 1'b1;
              wr      = 1'b1;
            end
          end
        end
        OP_POP: begin
          if (!ctl_i.done && valid_q && (ticket_q == tkt_i)) begin
            ctl_d.done = 1'b1;
            valid_d    = 1'b0;
            pop_d      = value_q;
          end
        end
        OP_COUNT: begin
          if (valid_q && (value_q == val_i)) begin
            cnt_d = cnt_i + CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      ctl_q   <= '0;
    end else begin
      valid_q <= valid_d;
      ctl_q   <= ctl_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (wr) begin
      value_q  <= val_i;
      ticket_q <= tkt_i;
    end
    val_q <= val_i;
    tkt_q <= tkt_i;
    cnt_q <= cnt_d;
    pop_q <= pop_d;
  end

  assign ctl_o = ctl_q;
  assign val_o = val_q;
  assign tkt_o = tkt_q;
  assign cnt_o = cnt_q;
  assign pop_o = pop_q;

endmodule

[bench/receipt_tagged_store_top_test.sv]
module receipt_tagged_store_top_test;
  import rts_pkg::*;

  localparam int unsigned SLOTS         = 16;
  localparam int unsigned RANDOM_ITEMS  = 1750;
  localparam int unsigned QUIET_TAIL    = 250;
  localparam int unsigned TIMEOUT_UNITS = 4_000_000;

  // op code the block leaves unused
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       start_i;
  logic                       busy_o;
  logic [OP_W-1:0]            op_i;
  logic signed [ITEM_W-1:0]   item_value_i;
  logic [TICKET_W-1:0]        ticket_i;
  logic                       done_o;
  logic [STATUS_W-1:0]        status_o;
  logic [TICKET_W-1:0]        issued_ticket_o;
  logic signed [ITEM_W-1:0]   popped_value_o;
  logic [COUNT_W-1:0]         match_count_o;
  logic [COUNT_W-1:0]         occupancy_o;

  // Mirror of the slot row plus the queue of outcomes still owed by the block
  class store_scoreboard;
    typedef struct packed {
      status_e             status;
      logic [TICKET_W-1:0] issued;
      logic [ITEM_W-1:0]   popped;
      logic [COUNT_W-1:0]  hits;
      logic [COUNT_W-1:0]  occupancy;
    } outcome_t;

    logic [ITEM_W-1:0]   cell_value[SLOTS];
    logic [TICKET_W-1:0] cell_receipt[SLOTS];
    bit                  cell_used[SLOTS];
    logic [TICKET_W-1:0] last_receipt;
    int unsigned         held;
    int unsigned         peak_held;
    int unsigned         errors;
    int unsigned         status_seen[4];
    outcome_t            outcome_q[$];

    function new();
      foreach (cell_used[i]) begin
        cell_used[i]    = 1'b0;
        cell_value[i]   = '0;
        cell_receipt[i] = '0;
      end
      foreach (status_seen[i]) status_seen[i] = 0;
      last_receipt = '0;
      held         = 0;
      peak_held    = 0;
      errors       = 0;
    endfunction

    // Apply one accepted command to the mirror and queue what it must return
    function void note_command(logic [OP_W-1:0] op, logic [ITEM_W-1:0] value,
                               logic [TICKET_W-1:0] ticket);
      outcome_t o;
      int       slot;
      o        = '0;
      o.status = ST_OK;
      slot     = -1;
      case (op)
        OP_INSERT: begin
          // lowest free slot; full is checked ahead of receipt exhaustion
          foreach (cell_used[i]) if (!cell_used[i] && slot < 0) slot = i;
          if (slot < 0) begin
            o.status = ST_FULL;
          end else if (last_receipt == '1) begin
            o.status = ST_EXHAUSTED;
          end else begin
            last_receipt       = last_receipt + 1;
            cell_value[slot]   = value;
            cell_receipt[slot] = last_receipt;
            cell_used[slot]    = 1'b1;
            held++;
            o.issued = last_receipt;
          end
        end
        OP_POP: begin
          foreach (cell_used[i])
            if (cell_used[i] && cell_receipt[i] == ticket && slot < 0) slot = i;
          if (slot < 0) begin
            o.status = ST_NOT_FOUND;
          end else begin
            o.popped        = cell_value[slot];
            cell_used[slot] = 1'b0;
            if (held > 0) held--;
          end
        end
        OP_COUNT: begin
          foreach (cell_used[i])
            if (cell_used[i] && cell_value[i] == value) o.hits++;
        end
        default: ;
      endcase
      o.occupancy = COUNT_W'(held);
      if (held > peak_held) peak_held = held;
      outcome_q = {outcome_q, o};
    endfunction

    // Compare one result beat against the oldest owed outcome
    function void check_result(logic [STATUS_W-1:0] status, logic [TICKET_W-1:0] issued,
                               logic [ITEM_W-1:0] popped, logic [COUNT_W-1:0] hit_count,
                               logic [COUNT_W-1:0] occupancy);
      outcome_t o;
      if (outcome_q.size() == 0) begin
        $error("result beat with no command outstanding");
        errors++;
        return;
      end
      o = outcome_q.pop_front();
      if (status !== o.status) begin
        $error("status: expected %0d, actual %0d", o.status, status);
        errors++;
      end
      if (issued !== o.issued) begin
        $error("issued_ticket: expected %h, actual %h", o.issued, issued);
        errors++;
      end
      if (popped !== o.popped) begin
        $error("popped_value: expected %h, actual %h", o.popped, popped);
        errors++;
      end
      if (hit_count !== o.hits) begin
        $error("match_count: expected %0d, actual %0d", o.hits, hit_count);
        errors++;
      end
      if (occupancy !== o.occupancy) begin
        $error("occupancy: expected %0d, actual %0d", o.occupancy, occupancy);
        errors++;
      end
      status_seen[o.status]++;
    endfunction

    // A receipt that is stored right now, picked at random
    function logic [TICKET_W-1:0] live_receipt();
      int picks[$];
      foreach (cell_used[i]) if (cell_used[i]) picks = {picks, i};
      if (picks.size() == 0) return '0;
      return cell_receipt[picks[$urandom_range(0, picks.size() - 1)]];
    endfunction
  endclass

  store_scoreboard store = new();
  int unsigned     commands_sent = 0;

  receipt_tagged_store_top #(
    .CAPACITY    (SLOTS),
    .VALUE_WIDTH (32)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .op_i            (op_i),
    .item_value_i    (item_value_i),
    .ticket_i        (ticket_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .issued_ticket_o (issued_ticket_o),
    .popped_value_o  (popped_value_o),
    .match_count_o   (match_count_o),
    .occupancy_o     (occupancy_o)
  );

  // clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // result beats are checked at the edge that ends their strobe cycle
  always @(posedge clk_i) begin
    if (rst_ni && done_o)
      store.check_result(status_o, issued_ticket_o, popped_value_o, match_count_o,
                         occupancy_o);
  end

  // values picked often so that count finds matches
  function automatic logic [ITEM_W-1:0] pool_value();
    case ($urandom_range(0, 5))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0000_0000;
      4:       return 32'h0000_0001;
      default: return 32'h5A5A_A5A5;
    endcase
  endfunction

  // One command beat, optionally after an idle burst; returns once it is taken
  task automatic send_command(input logic [OP_W-1:0] op, input logic [ITEM_W-1:0] value,
                              input logic [TICKET_W-1:0] ticket, input bit allow_idle);
    int gap;
    if (allow_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i      <= 1'b1;
    op_i         <= op;
    item_value_i <= value;
    ticket_i     <= ticket;
    do @(posedge clk_i); while (busy_o);
    store.note_command(op, value, ticket);
    commands_sent++;
  endtask

  // stimulus
  initial begin
    int              regime;
    int              r;
    logic [OP_W-1:0] op;
    logic [31:0]     v;
    logic [31:0]     t;
    int              ins_cut[3];
    int              pop_cut[3];

    // fill-heavy, drain-heavy and balanced mixes
    ins_cut = '{60, 20, 35};
    pop_cut = '{80, 75, 70};
    regime  = 0;

    rst_ni       <= 1'b0;
    start_i      <= 1'b0;
    op_i         <= OP_INSERT;
    item_value_i <= '0;
    ticket_i     <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty store: count, unknown receipt zero, unused op with all ones
    send_command(OP_COUNT, '0, '0, 1'b1);
    send_command(OP_POP, $urandom(), '0, 1'b1);
    send_command(OP_UNUSED, '1, '1, 1'b1);

    // fill every slot, value extremes and a duplicate first
    for (int i = 0; i < SLOTS; i++) begin
      case (i)
        0:       v = 32'h8000_0000;
        1:       v = 32'h7FFF_FFFF;
        2, 4:    v = 32'hFFFF_FFFF;
        3:       v = 32'h0000_0000;
        default: v = $urandom();
      endcase
      send_command(OP_INSERT, v, $urandom(), 1'b1);
    end

    // full store, duplicate count, pop of first receipt twice, all-ones receipt
    send_command(OP_INSERT, 32'd5, '0, 1'b1);
    send_command(OP_COUNT, 32'hFFFF_FFFF, '0, 1'b1);
    send_command(OP_POP, '0, 32'd1, 1'b1);
    send_command(OP_POP, '0, 32'd1, 1'b1);
    send_command(OP_POP, '0, '1, 1'b1);
    send_command(OP_UNUSED, '0, '0, 1'b1);

    // random mix; receipt exhaustion needs 2^32 - 1 inserts and is out of reach here
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 60 == 0) regime = $urandom_range(0, 2);
      r = $urandom_range(0, 99);
      v = ($urandom_range(0, 1) == 0) ? pool_value() : $urandom();
      t = $urandom();
      if (r < ins_cut[regime]) begin
        op = OP_INSERT;
      end else if (r < pop_cut[regime]) begin
        op = OP_POP;
        // mostly live receipts; else stale, not yet issued or random ones
        if (store.held != 0 && $urandom_range(0, 4) != 0)
          t = store.live_receipt();
        else if ($urandom_range(0, 1) == 0)
          t = $urandom_range(0, store.last_receipt + 2);
      end else if (r < 96) begin
        op = OP_COUNT;
      end else begin
        op = OP_UNUSED;
      end
      send_command(op, v, t, n < RANDOM_ITEMS - QUIET_TAIL);
    end
    start_i <= 1'b0;

    // drain, then give the row time to show any stray beat
    while (store.outcome_q.size() != 0) @(posedge clk_i);
    repeat (2 * (SLOTS + 1)) @(posedge clk_i);

    $display("Ran %0d commands: %0d ok, %0d full, %0d unknown receipt, %0d exhausted",
             commands_sent, store.status_seen[ST_OK], store.status_seen[ST_FULL],
             store.status_seen[ST_NOT_FOUND], store.status_seen[ST_EXHAUSTED]);
    $display("Peak occupancy %0d of %0d slots, last receipt issued %0d",
             store.peak_held, SLOTS, store.last_receipt);
    if (store.errors == 0 && store.outcome_q.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // watchdog
  initial begin
    #(TIMEOUT_UNITS);
    $display("Regression FAIL");
    $finish;
  end

endmodule
